// ===== sv/pwpt_pkg.sv =====
// ----------------------------------------------------------------------------
// pwpt_pkg
// Shared types and constants for the pulse-width coded frame transmitter.
// ----------------------------------------------------------------------------
`default_nettype none

package pwpt_pkg;

  // frame geometry
  localparam int unsigned FRAME_BYTES = 4;
  localparam int unsigned FRAME_BITS  = FRAME_BYTES * 8;
  localparam int unsigned BIT_POS_W   = $clog2(FRAME_BITS);
  localparam logic [BIT_POS_W-1:0] LAST_BIT_POS = BIT_POS_W'(FRAME_BITS - 1);

  // line timing in ticks
  localparam logic [3:0] PREAMBLE_HIGH_TICKS = 4'd10;
  localparam logic [3:0] ONE_HIGH_TICKS      = 4'd2;
  localparam logic [3:0] ZERO_HIGH_TICKS     = 4'd1;

  // battery byte codes
  localparam logic [7:0] BAT_NONE  = 8'd0;
  localparam logic [7:0] BAT_BASE  = 8'd8;
  localparam logic [7:0] BAT_ONE   = 8'd11;
  localparam logic [7:0] BAT_TWO   = 8'd22;
  localparam logic [7:0] BAT_THREE = 8'd33;
  localparam logic [7:0] BAT_FOUR  = 8'd44;
  localparam logic [7:0] BAT_FIVE  = 8'd55;

  // op codes of an input word
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SEND = 1'b1;

  // register file
  localparam int unsigned ADDR_W = 5;
  localparam logic [2:0] REG_DEVICE_ID       = 3'd0;
  localparam logic [2:0] REG_THRESHOLD_ONE   = 3'd1;
  localparam logic [2:0] REG_THRESHOLD_TWO   = 3'd2;
  localparam logic [2:0] REG_THRESHOLD_THREE = 3'd3;
  localparam logic [2:0] REG_THRESHOLD_FOUR  = 3'd4;
  localparam logic [2:0] REG_THRESHOLD_FIVE  = 3'd5;

  typedef enum logic [1:0] {
    PH_PRE_HIGH = 2'd0,
    PH_PRE_LOW  = 2'd1,
    PH_BIT_HIGH = 2'd2,
    PH_BIT_LOW  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] device_id;
    logic [9:0] threshold_one;
    logic [9:0] threshold_two;
    logic [9:0] threshold_three;
    logic [9:0] threshold_four;
    logic [9:0] threshold_five;
  } cfg_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic accepted;
    logic frame_done;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/pwpt_regs.sv =====
// ----------------------------------------------------------------------------
// pwpt_regs
// APB register file: device id and the five battery thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

module pwpt_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [pwpt_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  output pwpt_pkg::cfg_t                   cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[pwpt_pkg::ADDR_W-1:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        pwpt_pkg::REG_DEVICE_ID:       cfg.device_id       <= pwdata[7:0];
        pwpt_pkg::REG_THRESHOLD_ONE:   cfg.threshold_one   <= pwdata[9:0];
        pwpt_pkg::REG_THRESHOLD_TWO:   cfg.threshold_two   <= pwdata[9:0];
        pwpt_pkg::REG_THRESHOLD_THREE: cfg.threshold_three <= pwdata[9:0];
        pwpt_pkg::REG_THRESHOLD_FOUR:  cfg.threshold_four  <= pwdata[9:0];
        pwpt_pkg::REG_THRESHOLD_FIVE:  cfg.threshold_five  <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      pwpt_pkg::REG_DEVICE_ID:       prdata = {24'd0, cfg.device_id};
      pwpt_pkg::REG_THRESHOLD_ONE:   prdata = {22'd0, cfg.threshold_one};
      pwpt_pkg::REG_THRESHOLD_TWO:   prdata = {22'd0, cfg.threshold_two};
      pwpt_pkg::REG_THRESHOLD_THREE: prdata = {22'd0, cfg.threshold_three};
      pwpt_pkg::REG_THRESHOLD_FOUR:  prdata = {22'd0, cfg.threshold_four};
      pwpt_pkg::REG_THRESHOLD_FIVE:  prdata = {22'd0, cfg.threshold_five};
      default:                       prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/pwpt_frame_build.sv =====
// ----------------------------------------------------------------------------
// pwpt_frame_build
// Builds the 32-bit frame word: id, code, battery byte and their byte sum.
// ----------------------------------------------------------------------------
`default_nettype none

module pwpt_frame_build (
  input  wire pwpt_pkg::cfg_t                   cfg,
  input  wire logic [7:0]                       message_code,
  input  wire logic                             report_battery,
  input  wire logic [9:0]                       battery_reading,
  output logic      [pwpt_pkg::FRAME_BITS-1:0]  frame
);

  logic [7:0] level;
  logic [7:0] bat;
  logic [7:0] sum;

  // classify reading, highest-numbered matching threshold wins
  always_comb begin
    level = pwpt_pkg::BAT_BASE;
    if (battery_reading <= cfg.threshold_one)   level = pwpt_pkg::BAT_ONE;
    if (battery_reading <= cfg.threshold_two)   level = pwpt_pkg::BAT_TWO;
    if (battery_reading <= cfg.threshold_three) level = pwpt_pkg::BAT_THREE;
    if (battery_reading <= cfg.threshold_four)  level = pwpt_pkg::BAT_FOUR;
    if (battery_reading <= cfg.threshold_five)  level = pwpt_pkg::BAT_FIVE;
  end

  assign bat = report_battery ? level : pwpt_pkg::BAT_NONE;

  // modulo-256 checksum
  assign sum   = cfg.device_id + message_code + bat;
  assign frame = {sum, bat, message_code, cfg.device_id};

endmodule

`default_nettype wire

// ===== sv/pwpt_sequencer.sv =====
// ----------------------------------------------------------------------------
// pwpt_sequencer
// Frame state machine: preamble, then pulse-width coded bits, one tick a step.
// ----------------------------------------------------------------------------
`default_nettype none

module pwpt_sequencer (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            step,
  input  wire logic                            op,
  input  wire logic [pwpt_pkg::FRAME_BITS-1:0] frame,
  output pwpt_pkg::result_t                    res
);

  pwpt_pkg::phase_t                   phase, phase_next;
  logic [3:0]                         tick_count, tick_count_next;
  logic [pwpt_pkg::BIT_POS_W-1:0]     bit_position, bit_position_next;
  logic                               sending, sending_next;
  logic [pwpt_pkg::FRAME_BITS-1:0]    frame_shift, frame_shift_next;
  logic [3:0]                         tick_inc;
  logic [3:0]                         need;

  assign tick_inc = tick_count + 4'd1;
  assign need     = frame_shift[bit_position] ? pwpt_pkg::ONE_HIGH_TICKS
                                              : pwpt_pkg::ZERO_HIGH_TICKS;

  // state registers, advanced once per accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= pwpt_pkg::PH_PRE_HIGH;
      tick_count   <= '0;
      bit_position <= '0;
      sending      <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      tick_count   <= tick_count_next;
      bit_position <= bit_position_next;
      sending      <= sending_next;
    end
  end

  // frame word needs no reset, it is only read while sending
  always_ff @(posedge clk) begin
    if (step) begin
      frame_shift <= frame_shift_next;
    end
  end

  // next state and result
  always_comb begin
    phase_next        = phase;
    tick_count_next   = tick_count;
    bit_position_next = bit_position;
    sending_next      = sending;
    frame_shift_next  = frame_shift;
    res               = '0;

    if (op == pwpt_pkg::OP_SEND) begin
      // send request: load when idle, reject when busy
      if (!sending) begin
        frame_shift_next  = frame;
        bit_position_next = '0;
        phase_next        = pwpt_pkg::PH_PRE_HIGH;
        tick_count_next   = '0;
        sending_next      = 1'b1;
        res.accepted      = 1'b1;
      end
      res.busy_res = 1'b1;
    end else if (sending) begin
      res.busy_res = 1'b1;
      case (phase)
        pwpt_pkg::PH_PRE_HIGH: begin
          res.line_level = 1'b1;
          if (tick_inc >= pwpt_pkg::PREAMBLE_HIGH_TICKS) begin
            phase_next      = pwpt_pkg::PH_PRE_LOW;
            tick_count_next = '0;
          end else begin
            tick_count_next = tick_inc;
          end
        end
        pwpt_pkg::PH_PRE_LOW: begin
          phase_next        = pwpt_pkg::PH_BIT_HIGH;
          tick_count_next   = '0;
          bit_position_next = '0;
        end
        pwpt_pkg::PH_BIT_HIGH: begin
          res.line_level = 1'b1;
          if (tick_inc >= need) begin
            phase_next      = pwpt_pkg::PH_BIT_LOW;
            tick_count_next = '0;
          end else begin
            tick_count_next = tick_inc;
          end
        end
        pwpt_pkg::PH_BIT_LOW: begin
          tick_count_next = '0;
          if (bit_position == pwpt_pkg::LAST_BIT_POS) begin
            res.frame_done    = 1'b1;
            sending_next      = 1'b0;
            phase_next        = pwpt_pkg::PH_PRE_HIGH;
            bit_position_next = '0;
          end else begin
            bit_position_next = bit_position + 1'b1;
            phase_next        = pwpt_pkg::PH_BIT_HIGH;
          end
        end
        default: begin
          phase_next = pwpt_pkg::PH_PRE_HIGH;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/pulse_width_packet_transmitter.sv =====
// ----------------------------------------------------------------------------
// pulse_width_packet_transmitter
// Pulse-width coded four-byte frame transmitter driven by tick words.
// ----------------------------------------------------------------------------
// Every input word (a tick or a send request) produces exactly one result word,
// and one input word is taken per clock cycle unless the output side stalls.
// The result of a word is computed in the cycle it is accepted and sits in the
// output register from the next cycle on; a new input word is taken in the same
// cycle the output register is emptied, so the rate is set only by stalls on the
// output side. A send request loads the frame (device id, code, battery byte,
// checksum) and each following tick word steps the line through the preamble
// and the 32 coded bits. Write the registers only while no frame is being sent.
`default_nettype none

module pulse_width_packet_transmitter (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // input channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        op,
  input  wire logic [7:0]                  message_code,
  input  wire logic                        report_battery,
  input  wire logic [9:0]                  battery_reading,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             line_level,
  output logic                             busy_res,
  output logic                             accepted,
  output logic                             frame_done,
  // configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [pwpt_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);

  pwpt_pkg::cfg_t                   cfg;
  logic [pwpt_pkg::FRAME_BITS-1:0]  frame;
  pwpt_pkg::result_t                res;
  pwpt_pkg::result_t                res_q;
  logic                             step;

  pwpt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pwpt_frame_build u_frame_build (
    .cfg             (cfg),
    .message_code    (message_code),
    .report_battery  (report_battery),
    .battery_reading (battery_reading),
    .frame           (frame)
  );

  pwpt_sequencer u_sequencer (
    .clk   (clk),
    .rst   (rst),
    .step  (step),
    .op    (op),
    .frame (frame),
    .res   (res)
  );

  // take a word whenever the output register is free or being drained
  assign in_stall = out_valid & out_stall;
  assign step     = in_valid & ~in_stall;

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign line_level = res_q.line_level;
  assign busy_res   = res_q.busy_res;
  assign accepted   = res_q.accepted;
  assign frame_done = res_q.frame_done;

endmodule

`default_nettype wire

// ===== sv/pwpt_checker.sv =====
// ----------------------------------------------------------------------------
// pwpt_checker
// Port-level checks on the transmitter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pwpt_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic line_level,
  input wire logic busy_res,
  input wire logic accepted,
  input wire logic frame_done
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(line_level) && $stable(busy_res)
      && $stable(accepted) && $stable(frame_done))
    else $error("result word changed while stalled");

  // an accepted request is never a time tick
  a_accept_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |-> busy_res && !line_level && !frame_done)
    else $error("accepted request drove the line or ended a frame");

  // the last tick of a frame is a low tick of a busy frame
  a_done_low: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> busy_res && !line_level && !accepted)
    else $error("frame end on a high or idle tick");

  // an idle result carries nothing
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && !busy_res |-> !line_level && !accepted && !frame_done)
    else $error("activity reported while idle");

endmodule

bind pulse_width_packet_transmitter pwpt_checker u_pwpt_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .line_level (line_level),
  .busy_res   (busy_res),
  .accepted   (accepted),
  .frame_done (frame_done)
);

`default_nettype wire
